// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the ring producer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/trenq_pkg.sv =====
// Shared widths, result codes and transfer block constants of the ring producer.
package trenq_pkg;

	localparam int SLOT_W = 8;
	localparam int EP_W   = 5;
	localparam int ADDR_W = 64;
	localparam int WORD_W = 32;
	localparam int KIND_W = 3;

	// Request kinds.
	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_ENQUEUE = 1'b1;

	// Result kinds.
	localparam logic [KIND_W-1:0] RK_BLOCK    = 3'd0;
	localparam logic [KIND_W-1:0] RK_LINK     = 3'd1;
	localparam logic [KIND_W-1:0] RK_DOORBELL = 3'd2;
	localparam logic [KIND_W-1:0] RK_REPLY    = 3'd3;
	localparam logic [KIND_W-1:0] RK_ERROR    = 3'd4;

	// Link block type field and toggle-cycle flag, placed in word 3.
	localparam logic [WORD_W-1:0] LINK_TYPE   = 32'd6;
	localparam logic [WORD_W-1:0] LINK_TOGGLE = 32'h0000_0002;
	localparam logic [WORD_W-1:0] LINK_WORD3  = (LINK_TYPE << 10) | LINK_TOGGLE;

	// Clears the cycle bit of a caller supplied word 3.
	localparam logic [WORD_W-1:0] CYCLE_CLEAR = 32'hFFFF_FFFE;

endpackage

// ===== rtl/trenq_req_if.sv =====
// Request channel interface: one allocate or enqueue item per transfer.
interface trenq_req_if;
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic [trenq_pkg::SLOT_W-1:0]    slot_number;
	logic [trenq_pkg::EP_W-1:0]      endpoint_number;
	logic [trenq_pkg::ADDR_W-1:0]    page_base;
	logic [trenq_pkg::WORD_W-1:0]    block_word0;
	logic [trenq_pkg::WORD_W-1:0]    block_word1;
	logic [trenq_pkg::WORD_W-1:0]    block_word2;
	logic [trenq_pkg::WORD_W-1:0]    block_word3;
	logic                            ring_doorbell;

	modport source (
		output valid, kind, slot_number, endpoint_number, page_base,
		output block_word0, block_word1, block_word2, block_word3, ring_doorbell,
		input  ready
	);

	modport sink (
		input  valid, kind, slot_number, endpoint_number, page_base,
		input  block_word0, block_word1, block_word2, block_word3, ring_doorbell,
		output ready
	);
endinterface

// ===== rtl/trenq_rsp_if.sv =====
// Result channel interface: one memory write, reply or error per transfer.
interface trenq_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [trenq_pkg::KIND_W-1:0]    result_kind;
	logic [trenq_pkg::ADDR_W-1:0]    target_address;
	logic [trenq_pkg::WORD_W-1:0]    out_word0;
	logic [trenq_pkg::WORD_W-1:0]    out_word1;
	logic [trenq_pkg::WORD_W-1:0]    out_word2;
	logic [trenq_pkg::WORD_W-1:0]    out_word3;
	logic                            last_of_run;

	modport source (
		output valid, result_kind, target_address,
		output out_word0, out_word1, out_word2, out_word3, last_of_run,
		input  ready
	);

	modport sink (
		input  valid, result_kind, target_address,
		input  out_word0, out_word1, out_word2, out_word3, last_of_run,
		output ready
	);
endinterface

// ===== rtl/trenq_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module trenq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/transfer_ring_enqueue_engine.sv =====
// Top level of the transfer ring producer: microcoded sequencer over a context RAM.
// An item scans the N claimed contexts (N up to CONTEXTS) in order, one RAM read per cycle,
// until the first match; its first result is registered by the emitting step of its route,
// and further results follow with at most the commit step between them. A new item is
// taken only when the sequencer is back in its idle step.
// Reset clears the fill count, the sequencer and the output register; the RAM is not cleared.
`include "assert_macros.svh"

module transfer_ring_enqueue_engine #(
	parameter int CONTEXTS     = 256,
	parameter int RING_ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [trenq_pkg::ADDR_W-1:0]  cfg_data,
	trenq_req_if.sink                     req,
	trenq_rsp_if.source                   rsp
);

	localparam int IW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
	localparam int CW = $clog2(CONTEXTS + 1);
	localparam int PW = $clog2(RING_ENTRIES);
	localparam logic [PW-1:0] LAST_POS = PW'(RING_ENTRIES - 2);
	localparam logic [PW-1:0] LINK_POS = PW'(RING_ENTRIES - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(CONTEXTS);

	// One ring context as kept in the RAM.
	typedef struct packed {
		logic [trenq_pkg::ADDR_W-1:0] base;
		logic [trenq_pkg::SLOT_W-1:0] slot;
		logic [trenq_pkg::EP_W-1:0]   ep;
		logic [PW-1:0]                pos;
		logic                         pcs;
	} ctx_t;

	// Sequencer steps, i.e. the addresses of the control program.
	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_ROUTE, ST_AL_HIT, ST_AL_FULL, ST_CLAIM, ST_RESTART,
		ST_REPLY, ST_EQ_HIT, ST_BLOCK, ST_LINK, ST_COMMIT, ST_BELL, ST_ERROR
	} step_t;

	// Datapath operations.
	typedef enum logic [3:0] {
		OP_NONE, OP_ACCEPT, OP_SCAN, OP_CLAIM, OP_RESTART, OP_COMMIT,
		OP_EMIT_REPLY, OP_EMIT_ERROR, OP_EMIT_BLOCK, OP_EMIT_LINK, OP_EMIT_BELL
	} op_t;

	// Jump conditions.
	typedef enum logic [3:0] {
		C_ALWAYS, C_IN, C_SCAN_DONE, C_ENQ, C_HIT, C_FULL, C_MISS, C_NOWRAP, C_NOBELL
	} cond_t;

	// One control word: operation, jump condition and target, and whether to
	// stay on this step while the condition is false.
	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		logic  hold;
	} ctrl_t;

	// The control program.
	function automatic ctrl_t ucode(step_t s);
		case (s)
			ST_IDLE:    ucode = '{OP_ACCEPT,     C_IN,        ST_SCAN,    1'b1};
			ST_SCAN:    ucode = '{OP_SCAN,       C_SCAN_DONE, ST_ROUTE,   1'b1};
			ST_ROUTE:   ucode = '{OP_NONE,       C_ENQ,       ST_EQ_HIT,  1'b0};
			ST_AL_HIT:  ucode = '{OP_NONE,       C_HIT,       ST_RESTART, 1'b0};
			ST_AL_FULL: ucode = '{OP_NONE,       C_FULL,      ST_ERROR,   1'b0};
			ST_CLAIM:   ucode = '{OP_CLAIM,      C_ALWAYS,    ST_REPLY,   1'b0};
			ST_RESTART: ucode = '{OP_RESTART,    C_ALWAYS,    ST_REPLY,   1'b0};
			ST_REPLY:   ucode = '{OP_EMIT_REPLY, C_ALWAYS,    ST_IDLE,    1'b0};
			ST_EQ_HIT:  ucode = '{OP_NONE,       C_MISS,      ST_ERROR,   1'b0};
			ST_BLOCK:   ucode = '{OP_EMIT_BLOCK, C_NOWRAP,    ST_COMMIT,  1'b0};
			ST_LINK:    ucode = '{OP_EMIT_LINK,  C_ALWAYS,    ST_COMMIT,  1'b0};
			ST_COMMIT:  ucode = '{OP_COMMIT,     C_NOBELL,    ST_IDLE,    1'b0};
			ST_BELL:    ucode = '{OP_EMIT_BELL,  C_ALWAYS,    ST_IDLE,    1'b0};
			ST_ERROR:   ucode = '{OP_EMIT_ERROR, C_ALWAYS,    ST_IDLE,    1'b0};
			default:    ucode = '{OP_NONE,       C_ALWAYS,    ST_IDLE,    1'b0};
		endcase
	endfunction

	// Sequencer and control state.
	step_t                       step_q;
	logic [CW-1:0]               cnt_q;
	logic [CW-1:0]               issue_idx_q;
	logic                        rd_vld_s1;
	logic [IW-1:0]               rd_idx_s1;
	logic                        hit_q;
	logic [IW-1:0]               hit_idx_q;
	logic                        out_valid_q;
	logic [trenq_pkg::ADDR_W-1:0] doorbell_q;

	// Captured request.
	logic                         kind_q;
	logic [trenq_pkg::SLOT_W-1:0] slot_q;
	logic [trenq_pkg::EP_W-1:0]   ep_q;
	logic [trenq_pkg::ADDR_W-1:0] page_q;
	logic [trenq_pkg::WORD_W-1:0] w0_q, w1_q, w2_q, w3_q;
	logic                         bell_q;

	// Working copy of the selected context.
	logic [trenq_pkg::ADDR_W-1:0] base_q;
	logic [PW-1:0]                pos_q;
	logic                         pcs_q;

	// Output register.
	logic [trenq_pkg::KIND_W-1:0] rk_q;
	logic [trenq_pkg::ADDR_W-1:0] addr_q;
	logic [trenq_pkg::WORD_W-1:0] ow0_q, ow1_q, ow2_q, ow3_q;
	logic                         last_q;

	// Combinational control.
	ctrl_t                        ctrl;
	logic                         is_emit;
	logic                         load_ok;
	logic                         stall;
	logic                         emit_go;
	logic                         cond_true;
	logic                         wrap;
	logic                         scan_issue;
	logic                         scan_done;
	logic                         rd_match;
	step_t                        step_d;

	// RAM ports.
	logic                         ram_we;
	logic [IW-1:0]                ram_waddr;
	ctx_t                         ram_wdata;
	ctx_t                         rd_ctx;

	// Emitted result before it enters the output register.
	logic [trenq_pkg::KIND_W-1:0] e_kind;
	logic [trenq_pkg::ADDR_W-1:0] e_addr;
	logic [trenq_pkg::WORD_W-1:0] e_w0, e_w1, e_w2, e_w3;
	logic                         e_last;
	logic [trenq_pkg::ADDR_W-1:0] ring_addr;

	trenq_ram #(
		.WIDTH ($bits(ctx_t)),
		.DEPTH (CONTEXTS)
	) u_ctx_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (scan_issue),
		.raddr (issue_idx_q[IW-1:0]),
		.rdata (rd_ctx)
	);

	// Current control word and handshake with the output register.
	always_comb begin
		ctrl    = ucode(step_q);
		is_emit = ctrl.op inside {OP_EMIT_REPLY, OP_EMIT_ERROR, OP_EMIT_BLOCK,
			OP_EMIT_LINK, OP_EMIT_BELL};
		load_ok = !out_valid_q || rsp.ready;
		stall   = is_emit && !load_ok;
		emit_go = is_emit && load_ok;
	end

	// Scan of the claimed contexts, one read issued per cycle.
	always_comb begin
		scan_issue = (step_q == ST_SCAN) && !hit_q && (issue_idx_q < cnt_q);
		scan_done  = hit_q || (!(issue_idx_q < cnt_q) && !rd_vld_s1);
		rd_match   = rd_vld_s1 && !hit_q && (rd_ctx.slot == slot_q) && (rd_ctx.ep == ep_q);
		wrap       = (pos_q >= LAST_POS);
	end

	// Jump condition and next step.
	always_comb begin
		case (ctrl.cond)
			C_ALWAYS:    cond_true = 1'b1;
			C_IN:        cond_true = req.valid;
			C_SCAN_DONE: cond_true = scan_done;
			C_ENQ:       cond_true = (kind_q == trenq_pkg::REQ_ENQUEUE);
			C_HIT:       cond_true = hit_q;
			C_FULL:      cond_true = (cnt_q == FULL_CNT);
			C_MISS:      cond_true = !hit_q;
			C_NOWRAP:    cond_true = !wrap;
			C_NOBELL:    cond_true = !bell_q;
			default:     cond_true = 1'b0;
		endcase
		if (stall) begin
			step_d = step_q;
		end else if (cond_true) begin
			step_d = ctrl.target;
		end else if (ctrl.hold) begin
			step_d = step_q;
		end else begin
			step_d = step_t'(step_q + 4'd1);
		end
	end

	// Context RAM writes.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = hit_idx_q;
		ram_wdata = '{base: base_q, slot: slot_q, ep: ep_q, pos: pos_q, pcs: pcs_q};
		case (ctrl.op)
			OP_CLAIM: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[IW-1:0];
				ram_wdata = '{base: page_q, slot: slot_q, ep: ep_q, pos: '0, pcs: 1'b1};
			end
			OP_RESTART: begin
				ram_we    = 1'b1;
				ram_wdata = '{base: base_q, slot: slot_q, ep: ep_q, pos: '0, pcs: 1'b1};
			end
			OP_COMMIT: begin
				ram_we    = 1'b1;
			end
			default: begin
				ram_we    = 1'b0;
			end
		endcase
	end

	// Result contents for each emitting operation.
	always_comb begin
		ring_addr = base_q + trenq_pkg::ADDR_W'({pos_q, 4'b0000});
		e_kind    = trenq_pkg::RK_ERROR;
		e_addr    = '0;
		e_w0      = '0;
		e_w1      = '0;
		e_w2      = '0;
		e_w3      = '0;
		e_last    = 1'b1;
		case (ctrl.op)
			OP_EMIT_REPLY: begin
				e_kind = trenq_pkg::RK_REPLY;
				e_addr = base_q | trenq_pkg::ADDR_W'(1);
			end
			OP_EMIT_BLOCK: begin
				e_kind = trenq_pkg::RK_BLOCK;
				e_addr = ring_addr;
				e_w0   = w0_q;
				e_w1   = w1_q;
				e_w2   = w2_q;
				e_w3   = (w3_q & trenq_pkg::CYCLE_CLEAR) | trenq_pkg::WORD_W'(pcs_q);
				e_last = !wrap && !bell_q;
			end
			OP_EMIT_LINK: begin
				e_kind = trenq_pkg::RK_LINK;
				e_addr = ring_addr;
				e_w0   = base_q[31:0];
				e_w1   = base_q[63:32];
				e_w3   = trenq_pkg::LINK_WORD3 | trenq_pkg::WORD_W'(pcs_q);
				e_last = !bell_q;
			end
			OP_EMIT_BELL: begin
				e_kind = trenq_pkg::RK_DOORBELL;
				e_addr = doorbell_q + trenq_pkg::ADDR_W'({slot_q, 2'b00});
				e_w0   = trenq_pkg::WORD_W'(ep_q);
			end
			default: begin
				e_kind = trenq_pkg::RK_ERROR;
			end
		endcase
	end

	// Sequencer state, context working registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			cnt_q       <= '0;
			issue_idx_q <= '0;
			rd_vld_s1   <= 1'b0;
			rd_idx_s1   <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			out_valid_q <= 1'b0;
			doorbell_q  <= '0;
			kind_q      <= 1'b0;
			slot_q      <= '0;
			ep_q        <= '0;
			page_q      <= '0;
			w0_q        <= '0;
			w1_q        <= '0;
			w2_q        <= '0;
			w3_q        <= '0;
			bell_q      <= 1'b0;
			base_q      <= '0;
			pos_q       <= '0;
			pcs_q       <= 1'b0;
			rk_q        <= '0;
			addr_q      <= '0;
			ow0_q       <= '0;
			ow1_q       <= '0;
			ow2_q       <= '0;
			ow3_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			step_q <= step_d;

			if (cfg_we) begin
				doorbell_q <= cfg_data;
			end

			// Capture the request and restart the scan.
			if (ctrl.op == OP_ACCEPT && req.valid) begin
				kind_q      <= req.kind;
				slot_q      <= req.slot_number;
				ep_q        <= req.endpoint_number;
				page_q      <= req.page_base;
				w0_q        <= req.block_word0;
				w1_q        <= req.block_word1;
				w2_q        <= req.block_word2;
				w3_q        <= req.block_word3;
				bell_q      <= req.ring_doorbell;
				issue_idx_q <= '0;
				hit_q       <= 1'b0;
			end

			// Read pipeline of the scan and key compare on the returned entry.
			rd_vld_s1 <= scan_issue;
			rd_idx_s1 <= issue_idx_q[IW-1:0];
			if (scan_issue) begin
				issue_idx_q <= issue_idx_q + CW'(1);
			end
			if (rd_match) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_idx_s1;
				base_q    <= rd_ctx.base;
				pos_q     <= rd_ctx.pos;
				pcs_q     <= rd_ctx.pcs;
			end

			// A new context takes the supplied page base.
			if (ctrl.op == OP_CLAIM) begin
				cnt_q  <= cnt_q + CW'(1);
				base_q <= page_q;
			end

			// Position and cycle bit advance as blocks are written.
			if (emit_go && ctrl.op == OP_EMIT_BLOCK) begin
				pos_q <= pos_q + PW'(1);
			end
			if (emit_go && ctrl.op == OP_EMIT_LINK) begin
				pos_q <= '0;
				pcs_q <= !pcs_q;
			end

			// Output register loads a result or drains on a transfer.
			if (emit_go) begin
				out_valid_q <= 1'b1;
				rk_q        <= e_kind;
				addr_q      <= e_addr;
				ow0_q       <= e_w0;
				ow1_q       <= e_w1;
				ow2_q       <= e_w2;
				ow3_q       <= e_w3;
				last_q      <= e_last;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Channel outputs.
	assign req.ready          = (ctrl.op == OP_ACCEPT);
	assign rsp.valid          = out_valid_q;
	assign rsp.result_kind    = rk_q;
	assign rsp.target_address = addr_q;
	assign rsp.out_word0      = ow0_q;
	assign rsp.out_word1      = ow1_q;
	assign rsp.out_word2      = ow2_q;
	assign rsp.out_word3      = ow3_q;
	assign rsp.last_of_run    = last_q;

	// The fill count never passes the table size.
	`ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= FULL_CNT)
	// Claiming a context grows the fill count by exactly one.
	`ASSERT_NEXT(a_claim_count, ctrl.op == OP_CLAIM, cnt_q == $past(cnt_q) + CW'(1))
	// Existing contexts are only rewritten after the scan found them.
	`ASSERT_SAME(a_write_hit, ctrl.op == OP_COMMIT || ctrl.op == OP_RESTART, hit_q)
	// A link block is written only at the last entry of the ring.
	`ASSERT_SAME(a_link_pos, emit_go && ctrl.op == OP_EMIT_LINK, pos_q == LINK_POS)

endmodule
